FILE: sv/anf_pkg.sv
package anf_pkg;

  // Table geometry.
  localparam int FILTERS  = 8;
  localparam int NAME_MAX = 32;
  localparam int ADV_MAX  = 31;

  localparam int FILT_W   = $clog2(FILTERS);
  localparam int FCNT_W   = $clog2(FILTERS + 1);
  localparam int NAME_AW  = $clog2(NAME_MAX);
  localparam int LEN_W    = $clog2(NAME_MAX + 1);
  localparam int CHAR_AW  = FILT_W + NAME_AW;
  localparam int POS_W    = 8;

  // Request codes.
  localparam logic [1:0] REQ_PAYLOAD = 2'd0;
  localparam logic [1:0] REQ_CHAR    = 2'd1;
  localparam logic [1:0] REQ_HEADER  = 2'd2;

  // Structure types that carry a device name.
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_NAME_SHORT = 8'h08;

  typedef logic [LEN_W-1:0] len_t;

  // Packet summary handed from the parser to the matcher.
  typedef struct packed {
    len_t nlen;
    logic overflow;
  } anf_req_t;

  // One verdict.
  typedef struct packed {
    logic              pass;
    logic              name_found;
    len_t              name_length;
    logic [FILT_W-1:0] hit_index;
    logic              no_filters;
    logic              overflow;
  } anf_result_t;

endpackage

FILE: sv/anf_in_if.sv
interface anf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       last;
  logic [2:0] filter_index;
  logic [4:0] char_index;
  logic [5:0] filter_length;
  logic       filter_exact;
  logic       filter_valid;

  modport source (output valid, req_type, data_byte, last, filter_index, char_index,
                  filter_length, filter_exact, filter_valid, input ready);
  modport sink (input valid, req_type, data_byte, last, filter_index, char_index,
                filter_length, filter_exact, filter_valid, output ready);
endinterface

FILE: sv/anf_out_if.sv
interface anf_out_if;
  logic       valid;
  logic       ready;
  logic       pass;
  logic       name_found;
  logic [5:0] name_length;
  logic [2:0] hit_index;
  logic       no_filters;
  logic       overflow;

  modport source (output valid, pass, name_found, name_length, hit_index, no_filters,
                  overflow, input ready);
  modport sink (input valid, pass, name_found, name_length, hit_index, no_filters,
                overflow, output ready);
endinterface

FILE: sv/anf_ram.sv
module anf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/anf_parse.sv
module anf_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     byte_en,
  input  logic [7:0]               data_byte,
  input  logic                     last,
  output logic                     name_we,
  output logic [anf_pkg::NAME_AW-1:0] name_waddr,
  output logic                     verdict_go,
  output anf_pkg::anf_req_t        verdict_req
);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [anf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                rem_r, rem_nxt;
  logic [1:0]                phase_r, phase_nxt;
  anf_pkg::len_t             cnt_r, cnt_nxt;
  logic                      cap_r, cap_nxt;
  logic                      stop_r, stop_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [7:0]                rem_dec;

  assign rem_dec = rem_r - 8'd1;

  // Length-type-data walk, one byte per accepted item.
  always_comb begin
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    cap_nxt     = cap_r;
    stop_nxt    = stop_r;
    ovf_nxt     = ovf_r;
    name_we     = 1'b0;
    name_waddr  = cnt_r[anf_pkg::NAME_AW-1:0];
    verdict_go  = 1'b0;
    verdict_req = '0;
    if (byte_en) begin
      if (pos_r < anf_pkg::POS_W'(anf_pkg::ADV_MAX)) begin
        pos_nxt = pos_r + 1'b1;
        if (!stop_r) begin
          unique case (phase_r)
            PH_LEN: begin
              if (data_byte == 8'd0) begin
                stop_nxt = 1'b1;
              end else begin
                rem_nxt   = data_byte;
                phase_nxt = PH_TYPE;
              end
            end
            PH_TYPE: begin
              rem_nxt = rem_dec;
              cap_nxt = (data_byte == anf_pkg::AD_NAME_FULL) ||
                        (data_byte == anf_pkg::AD_NAME_SHORT);
              cnt_nxt = '0;
              if (rem_dec == 8'd0) begin
                if (cap_nxt) stop_nxt = 1'b1;
                else phase_nxt = PH_LEN;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              if (cap_r && cnt_r < anf_pkg::LEN_W'(anf_pkg::NAME_MAX)) begin
                name_we = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              rem_nxt = rem_dec;
              if (rem_dec == 8'd0) begin
                if (cap_r) stop_nxt = 1'b1;
                else phase_nxt = PH_LEN;
              end
            end
            default: begin
              phase_nxt = PH_LEN;
            end
          endcase
        end
      end else begin
        ovf_nxt = 1'b1;
      end
      // End of packet: hand off the summary and start over.
      if (last) begin
        verdict_go           = 1'b1;
        verdict_req.nlen     = (stop_nxt && cap_nxt) ? cnt_nxt : '0;
        verdict_req.overflow = ovf_nxt;
        pos_nxt   = '0;
        rem_nxt   = '0;
        phase_nxt = PH_LEN;
        cnt_nxt   = '0;
        cap_nxt   = 1'b0;
        stop_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rem_r   <= '0;
      phase_r <= PH_LEN;
      cnt_r   <= '0;
      cap_r   <= 1'b0;
      stop_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cap_r   <= cap_nxt;
      stop_r  <= stop_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

FILE: sv/anf_match.sv
module anf_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  anf_pkg::anf_req_t             req,
  input  anf_pkg::len_t                 flt_len [anf_pkg::FILTERS],
  input  logic                          flt_exact [anf_pkg::FILTERS],
  input  logic                          flt_use [anf_pkg::FILTERS],
  output logic [anf_pkg::NAME_AW-1:0]   name_raddr,
  input  logic [7:0]                    name_rdata,
  output logic [anf_pkg::CHAR_AW-1:0]   char_raddr,
  input  logic [7:0]                    char_rdata,
  output logic                          idle,
  output logic                          done,
  input  logic                          done_ack,
  output anf_pkg::anf_result_t          result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                   st_r, st_nxt;
  logic [anf_pkg::FCNT_W-1:0]   f_r, f_nxt;
  anf_pkg::len_t                start_r, start_nxt;
  anf_pkg::len_t                i_r, i_nxt;
  anf_pkg::len_t                nlen_r, nlen_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         none_r, none_nxt;
  logic                         hit_r, hit_nxt;
  logic [anf_pkg::FILT_W-1:0]   hit_at_r, hit_at_nxt;
  logic [anf_pkg::FILT_W-1:0]   fi;
  anf_pkg::len_t                flen;
  anf_pkg::len_t                pos;
  logic [anf_pkg::LEN_W:0]      win_end;

  assign fi      = f_r[anf_pkg::FILT_W-1:0];
  assign flen    = flt_len[fi];
  assign pos     = start_r + i_r;
  assign win_end = {1'b0, start_r} + {1'b0, flen};

  assign name_raddr = pos[anf_pkg::NAME_AW-1:0];
  assign char_raddr = {fi, i_r[anf_pkg::NAME_AW-1:0]};

  // Sequencer: each character compare passes a read state and a compare state through the shared comparator.
  always_comb begin
    st_nxt     = st_r;
    f_nxt      = f_r;
    start_nxt  = start_r;
    i_nxt      = i_r;
    nlen_nxt   = nlen_r;
    ovf_nxt    = ovf_r;
    none_nxt   = none_r;
    hit_nxt    = hit_r;
    hit_at_nxt = hit_at_r;
    unique case (st_r)
      ST_IDLE: begin
        if (go) begin
          st_nxt     = ST_SCAN;
          f_nxt      = '0;
          nlen_nxt   = req.nlen;
          ovf_nxt    = req.overflow;
          none_nxt   = 1'b1;
          hit_nxt    = 1'b0;
          hit_at_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (f_r == anf_pkg::FCNT_W'(anf_pkg::FILTERS)) begin
          st_nxt = ST_DONE;
        end else if (!flt_use[fi]) begin
          f_nxt = f_r + 1'b1;
        end else begin
          none_nxt = 1'b0;
          if (nlen_r == '0) begin
            f_nxt = f_r + 1'b1;
          end else if (!flt_exact[fi] && flen == '0) begin
            hit_nxt    = 1'b1;
            hit_at_nxt = fi;
            st_nxt     = ST_DONE;
          end else if ((flt_exact[fi] && flen != nlen_r) || flen > nlen_r) begin
            f_nxt = f_r + 1'b1;
          end else begin
            start_nxt = '0;
            i_nxt     = '0;
            st_nxt    = ST_RD;
          end
        end
      end
      ST_RD: begin
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (name_rdata == char_rdata) begin
          if (i_r + 1'b1 == flen) begin
            hit_nxt    = 1'b1;
            hit_at_nxt = fi;
            st_nxt     = ST_DONE;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = ST_RD;
          end
        end else if (win_end == {1'b0, nlen_r}) begin
          f_nxt  = f_r + 1'b1;
          st_nxt = ST_SCAN;
        end else begin
          start_nxt = start_r + 1'b1;
          i_nxt     = '0;
          st_nxt    = ST_RD;
        end
      end
      ST_DONE: begin
        if (done_ack) st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    f_r      <= f_nxt;
    start_r  <= start_nxt;
    i_r      <= i_nxt;
    nlen_r   <= nlen_nxt;
    ovf_r    <= ovf_nxt;
    none_r   <= none_nxt;
    hit_r    <= hit_nxt;
    hit_at_r <= hit_at_nxt;
  end

  assign idle = (st_r == ST_IDLE);
  assign done = (st_r == ST_DONE);

  always_comb begin
    result.pass        = none_r || hit_r;
    result.name_found  = (nlen_r != '0);
    result.name_length = nlen_r;
    result.hit_index   = hit_at_r;
    result.no_filters  = none_r;
    result.overflow    = ovf_r;
  end

endmodule

FILE: sv/adv_name_filter.sv
// Advertising name filter. Each input item is a payload byte, a filter character
// write or a filter header write. On the payload byte marked last, the block
// walks its eight-entry filter table and emits one item with the verdict; during
// that walk it is not ready. The walk runs through a single byte comparator fed
// by two memories (filter characters and captured name); each compared character
// passes a read state and a compare state, and each filter entry a scan state.
// A finished verdict also holds the input off for as long as the previous verdict
// still waits in the output register. Filter memory characters that were never
// written read as unknown values.
module adv_name_filter (
  input  logic       clk,
  input  logic       rst_n,
  anf_in_if.sink     in_if,
  anf_out_if.source  out_if
);

  logic                            acc;
  logic                            byte_en;
  logic                            char_we;
  logic                            hdr_we;
  logic                            name_we;
  logic [anf_pkg::NAME_AW-1:0]     name_waddr;
  logic [anf_pkg::NAME_AW-1:0]     name_raddr;
  logic [7:0]                      name_rdata;
  logic [anf_pkg::CHAR_AW-1:0]     char_raddr;
  logic [7:0]                      char_rdata;
  logic                            verdict_go;
  anf_pkg::anf_req_t               verdict_req;
  logic                            m_idle;
  logic                            m_done;
  logic                            m_ack;
  anf_pkg::anf_result_t            m_result;
  anf_pkg::len_t                   flt_len_r [anf_pkg::FILTERS];
  logic                            flt_exact_r [anf_pkg::FILTERS];
  logic                            flt_use_r [anf_pkg::FILTERS];
  logic                            out_valid_r;
  anf_pkg::anf_result_t            out_data_r;

  // Input decode.
  assign in_if.ready = m_idle;
  assign acc     = in_if.valid && in_if.ready;
  assign byte_en = acc && (in_if.req_type == anf_pkg::REQ_PAYLOAD);
  assign char_we = acc && (in_if.req_type == anf_pkg::REQ_CHAR) &&
                   (32'(in_if.filter_index) < anf_pkg::FILTERS) &&
                   (32'(in_if.char_index) < anf_pkg::NAME_MAX);
  assign hdr_we  = acc && (in_if.req_type == anf_pkg::REQ_HEADER) &&
                   (32'(in_if.filter_index) < anf_pkg::FILTERS);

  // Filter headers live in flops so the sequencer can read them at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < anf_pkg::FILTERS; k++) begin
        flt_len_r[k]   <= '0;
        flt_exact_r[k] <= 1'b1;
        flt_use_r[k]   <= 1'b0;
      end
    end else if (hdr_we) begin
      flt_len_r[in_if.filter_index[anf_pkg::FILT_W-1:0]] <=
        (in_if.filter_length > anf_pkg::LEN_W'(anf_pkg::NAME_MAX)) ?
        anf_pkg::LEN_W'(anf_pkg::NAME_MAX) : anf_pkg::len_t'(in_if.filter_length);
      flt_exact_r[in_if.filter_index[anf_pkg::FILT_W-1:0]] <= in_if.filter_exact;
      flt_use_r[in_if.filter_index[anf_pkg::FILT_W-1:0]]   <= in_if.filter_valid;
    end
  end

  anf_ram #(.WIDTH(8), .DEPTH(anf_pkg::FILTERS * anf_pkg::NAME_MAX)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr ({in_if.filter_index[anf_pkg::FILT_W-1:0],
             in_if.char_index[anf_pkg::NAME_AW-1:0]}),
    .wdata (in_if.data_byte),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  anf_ram #(.WIDTH(8), .DEPTH(anf_pkg::NAME_MAX)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (in_if.data_byte),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  anf_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (byte_en),
    .data_byte   (in_if.data_byte),
    .last        (in_if.last),
    .name_we     (name_we),
    .name_waddr  (name_waddr),
    .verdict_go  (verdict_go),
    .verdict_req (verdict_req)
  );

  anf_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (verdict_go),
    .req        (verdict_req),
    .flt_len    (flt_len_r),
    .flt_exact  (flt_exact_r),
    .flt_use    (flt_use_r),
    .name_raddr (name_raddr),
    .name_rdata (name_rdata),
    .char_raddr (char_raddr),
    .char_rdata (char_rdata),
    .idle       (m_idle),
    .done       (m_done),
    .done_ack   (m_ack),
    .result     (m_result)
  );

  // Output register.
  assign m_ack = m_done && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (m_ack) begin
      out_data_r <= m_result;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pass        = out_data_r.pass;
  assign out_if.name_found  = out_data_r.name_found;
  assign out_if.name_length = out_data_r.name_length;
  assign out_if.hit_index   = out_data_r.hit_index;
  assign out_if.no_filters  = out_data_r.no_filters;
  assign out_if.overflow    = out_data_r.overflow;

  // A last payload byte starts the table walk, so the input stalls next cycle.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    verdict_go |=> !in_if.ready)
    else $error("input still ready after end of packet");

  // With an empty table every packet passes.
  a_none_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.no_filters |-> out_if.pass)
    else $error("packet dropped with no filters");

  // Without a name, only an empty table lets a packet pass.
  a_noname: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.name_found |->
      out_if.name_length == '0 && out_if.pass == out_if.no_filters)
    else $error("verdict inconsistent with missing name");

  // A verdict is only loaded when the matcher finished its walk.
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(m_done))
    else $error("result loaded without a finished walk");

endmodule

FILE: dv/tb_adv_name_filter.sv
`timescale 1ns / 1ps

module tb_adv_name_filter;

  // Parser position within a length-type-data structure.
  typedef enum int {WALK_LEN, WALK_TYPE, WALK_DATA} walk_phase_t;

  typedef struct {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last;
    logic [2:0] filter_index;
    logic [4:0] char_index;
    logic [5:0] filter_length;
    logic       filter_exact;
    logic       filter_valid;
  } anf_item_t;

  localparam logic [1:0] REQ_NONE = 2'd3;

  // Tracks the filter table and the packet walk, and keeps the verdicts still owed.
  class name_verdict_board;
    logic [7:0]  fchar [anf_pkg::FILTERS][anf_pkg::NAME_MAX];
    int          flen [anf_pkg::FILTERS];
    bit          fexact [anf_pkg::FILTERS];
    bit          fuse [anf_pkg::FILTERS];
    logic [7:0]  nbuf [anf_pkg::NAME_MAX];
    int          ncount, bpos, srem;
    walk_phase_t phase;
    bit          capturing, stopped, ovf;
    anf_pkg::anf_result_t verdict_q[$];
    int          mismatches;

    function new();
      for (int f = 0; f < anf_pkg::FILTERS; f++) begin
        flen[f] = 0;
        fexact[f] = 1'b1;
        fuse[f] = 1'b0;
      end
      mismatches = 0;
      clear_walk();
    endfunction

    function void clear_walk();
      ncount = 0;
      bpos = 0;
      srem = 0;
      phase = WALK_LEN;
      capturing = 1'b0;
      stopped = 1'b0;
      ovf = 1'b0;
    endfunction

    function void close_structure();
      if (capturing) begin
        stopped = 1'b1;
      end else begin
        phase = WALK_LEN;
      end
    endfunction

    function void walk_byte(logic [7:0] b);
      if (stopped) return;
      case (phase)
        WALK_LEN: begin
          if (b == 8'd0) begin
            stopped = 1'b1;
          end else begin
            srem = int'(b);
            phase = WALK_TYPE;
          end
        end
        WALK_TYPE: begin
          srem--;
          capturing = (b == anf_pkg::AD_NAME_FULL || b == anf_pkg::AD_NAME_SHORT);
          ncount = 0;
          if (srem == 0) begin
            close_structure();
          end else begin
            phase = WALK_DATA;
          end
        end
        default: begin
          if (capturing && ncount < anf_pkg::NAME_MAX) begin
            nbuf[ncount] = b;
            ncount++;
          end
          srem--;
          if (srem == 0) close_structure();
        end
      endcase
    endfunction

    function bit entry_hits(int f, int nlen);
      bit same;
      if (fexact[f]) begin
        if (flen[f] != nlen) return 1'b0;
        for (int i = 0; i < nlen; i++) begin
          if (nbuf[i] !== fchar[f][i]) return 1'b0;
        end
        return 1'b1;
      end
      if (flen[f] == 0) return 1'b1;
      if (flen[f] > nlen) return 1'b0;
      for (int s = 0; s + flen[f] <= nlen; s++) begin
        same = 1'b1;
        for (int i = 0; i < flen[f]; i++) begin
          if (nbuf[s + i] !== fchar[f][i]) same = 1'b0;
        end
        if (same) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Notes one accepted input item and queues the verdict it causes, if any.
    function void note_item(anf_item_t it);
      anf_pkg::anf_result_t v;
      int nlen;
      bit none, hit;
      case (it.req_type)
        anf_pkg::REQ_CHAR: fchar[it.filter_index][it.char_index] = it.data_byte;
        anf_pkg::REQ_HEADER: begin
          flen[it.filter_index] = (it.filter_length > anf_pkg::NAME_MAX) ?
                                  anf_pkg::NAME_MAX : int'(it.filter_length);
          fexact[it.filter_index] = it.filter_exact;
          fuse[it.filter_index] = it.filter_valid;
        end
        anf_pkg::REQ_PAYLOAD: begin
          if (bpos < anf_pkg::ADV_MAX) begin
            bpos++;
            walk_byte(it.data_byte);
          end else begin
            ovf = 1'b1;
          end
          if (it.last) begin
            nlen = (stopped && capturing) ? ncount : 0;
            none = 1'b1;
            hit = 1'b0;
            v = '0;
            for (int f = 0; f < anf_pkg::FILTERS; f++) begin
              if (fuse[f]) begin
                none = 1'b0;
                if (!hit && nlen != 0 && entry_hits(f, nlen)) begin
                  hit = 1'b1;
                  v.hit_index = anf_pkg::FILT_W'(f);
                end
              end
            end
            v.pass = none || hit;
            v.name_found = (nlen != 0);
            v.name_length = anf_pkg::LEN_W'(nlen);
            v.no_filters = none;
            v.overflow = ovf;
            verdict_q.insert(verdict_q.size(), v);
            clear_walk();
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns: verdict mismatch: %s", $time, what);
    endtask

    // Compares one verdict from the block with the oldest one owed.
    task check_verdict(anf_pkg::anf_result_t got);
      anf_pkg::anf_result_t exp;
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected verdict %p", got));
        return;
      end
      exp = verdict_q.pop_front();
      if (got.pass !== exp.pass)
        report($sformatf("pass %b, expected %b", got.pass, exp.pass));
      if (got.name_found !== exp.name_found)
        report($sformatf("name_found %b, expected %b", got.name_found, exp.name_found));
      if (got.name_length !== exp.name_length)
        report($sformatf("name_length %0d, expected %0d", got.name_length, exp.name_length));
      if (got.hit_index !== exp.hit_index)
        report($sformatf("hit_index %0d, expected %0d", got.hit_index, exp.hit_index));
      if (got.no_filters !== exp.no_filters)
        report($sformatf("no_filters %b, expected %b", got.no_filters, exp.no_filters));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow %b, expected %b", got.overflow, exp.overflow));
    endtask
  endclass

  logic clk;
  logic rst_n;
  anf_in_if  in_if ();
  anf_out_if out_if ();

  adv_name_filter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  name_verdict_board board;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_left;
  int  items_sent;
  bit  char_set [anf_pkg::FILTERS][anf_pkg::NAME_MAX];
  logic [7:0] name_pool [$];

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #200ms;
    $display("tb_adv_name_filter: done, errors");
    $finish;
  end

  // Result side: ready chosen at the falling edge, long hold-off when asked.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor.
  initial begin
    anf_pkg::anf_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.pass = out_if.pass;
        got.name_found = out_if.name_found;
        got.name_length = out_if.name_length;
        got.hit_index = out_if.hit_index;
        got.no_filters = out_if.no_filters;
        got.overflow = out_if.overflow;
        board.check_verdict(got);
      end
    end
  end

  // Offers one item from a falling edge until it is accepted.
  task send_item(anf_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.req_type = it.req_type;
    in_if.data_byte = it.data_byte;
    in_if.last = it.last;
    in_if.filter_index = it.filter_index;
    in_if.char_index = it.char_index;
    in_if.filter_length = it.filter_length;
    in_if.filter_exact = it.filter_exact;
    in_if.filter_valid = it.filter_valid;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_item(it);
    if (it.req_type != REQ_NONE) items_sent++;
    if (it.req_type == anf_pkg::REQ_CHAR) char_set[it.filter_index][it.char_index] = 1'b1;
    @(negedge clk);
  endtask

  function anf_item_t blank_item(logic [1:0] req);
    anf_item_t it;
    it.req_type = req;
    it.data_byte = 8'($urandom);
    it.last = 1'($urandom);
    it.filter_index = 3'($urandom);
    it.char_index = 5'($urandom);
    it.filter_length = 6'($urandom);
    it.filter_exact = 1'($urandom);
    it.filter_valid = 1'($urandom);
    return it;
  endfunction

  task put_char(int f, int c, logic [7:0] ch);
    anf_item_t it;
    it = blank_item(anf_pkg::REQ_CHAR);
    it.filter_index = 3'(f);
    it.char_index = 5'(c);
    it.data_byte = ch;
    send_item(it);
  endtask

  task put_header(int f, int len, bit exact, bit in_use);
    anf_item_t it;
    it = blank_item(anf_pkg::REQ_HEADER);
    it.filter_index = 3'(f);
    it.filter_length = 6'(len);
    it.filter_exact = exact;
    it.filter_valid = in_use;
    send_item(it);
  endtask

  // Number of leading characters of an entry that have been written.
  function int written_prefix(int f);
    for (int c = 0; c < anf_pkg::NAME_MAX; c++) begin
      if (!char_set[f][c]) return c;
    end
    return anf_pkg::NAME_MAX;
  endfunction

  function logic [7:0] pick_char();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return name_pool[$urandom_range(name_pool.size() - 1)];
  endfunction

  // Loads a short string into an entry and enables it.
  task load_filter(int f, int len, bit exact);
    for (int c = 0; c < len; c++) put_char(f, c, pick_char());
    put_header(f, len, exact, 1'b1);
  endtask

  task send_bytes(logic [7:0] bytes [$]);
    anf_item_t it;
    for (int i = 0; i < bytes.size(); i++) begin
      it = blank_item(anf_pkg::REQ_PAYLOAD);
      it.data_byte = bytes[i];
      it.last = (i == bytes.size() - 1);
      send_item(it);
      // Now and then a filter item lands in the middle of a packet.
      if (i != bytes.size() - 1 && $urandom_range(29) == 0)
        put_char($urandom_range(anf_pkg::FILTERS - 1), $urandom_range(anf_pkg::NAME_MAX - 1),
                 pick_char());
    end
  endtask

  // Builds one packet: mostly well-formed structures, some broken or noisy.
  task send_packet();
    logic [7:0] pkt [$];
    int nstruct, nlen, f;
    logic [7:0] ty;
    pkt = {};
    nstruct = $urandom_range(0, 3);
    for (int s = 0; s < nstruct; s++) begin
      case ($urandom_range(4))
        0, 1: ty = anf_pkg::AD_NAME_FULL;
        2: ty = anf_pkg::AD_NAME_SHORT;
        default: ty = 8'($urandom);
      endcase
      nlen = $urandom_range(0, 10);
      f = $urandom_range(anf_pkg::FILTERS - 1);
      pkt.insert(pkt.size(), 8'(nlen + 1));
      pkt.insert(pkt.size(), ty);
      // Often reuse a stored filter string so that matches happen.
      if ($urandom_range(1) == 1 && board.flen[f] <= 12 &&
          written_prefix(f) >= board.flen[f]) begin
        for (int i = 0; i < $urandom_range(0, 2); i++) begin
          pkt.insert(pkt.size(), pick_char());
        end
        for (int i = 0; i < board.flen[f]; i++) pkt.insert(pkt.size(), board.fchar[f][i]);
        pkt[pkt.size() - 2 - board.flen[f] - 0] = pkt[pkt.size() - 2 - board.flen[f]];
        nlen = 0;
        for (int i = pkt.size() - 1; i >= 0; i--) begin
          if (pkt[i] === ty && i > 0) begin
            pkt[i - 1] = 8'(pkt.size() - i);
            break;
          end
        end
      end else begin
        for (int i = 0; i < nlen; i++) pkt.insert(pkt.size(), pick_char());
      end
    end
    case ($urandom_range(9))
      0: if (pkt.size() > 1) pkt = pkt[0 : $urandom_range(pkt.size() - 1)];
      1: pkt.insert($urandom_range(pkt.size()), 8'd0);
      2: for (int i = 0; i < $urandom_range(1, 8); i++) pkt.insert(pkt.size(), 8'($urandom));
      3: while (pkt.size() < anf_pkg::ADV_MAX + $urandom_range(1, 6))
           pkt.insert(pkt.size(), 8'($urandom));
      default: if ($urandom_range(1)) pkt.insert(pkt.size(), 8'd0);
    endcase
    if (pkt.size() == 0) pkt.insert(0, 8'($urandom));
    send_bytes(pkt);
  endtask

  // Holds the sender off until every owed verdict has come back.
  task wait_drained();
    in_if.valid = 1'b0;
    while (board.verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One random phase of roughly the given number of items.
  task random_phase(int quota);
    int stop_at, f;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      f = $urandom_range(anf_pkg::FILTERS - 1);
      case ($urandom_range(19))
        0, 1: load_filter(f, $urandom_range(0, 6), $urandom);
        2: put_char(f, $urandom_range(anf_pkg::NAME_MAX - 1), pick_char());
        3: begin
          if ($urandom_range(1)) begin
            put_header(f, $urandom_range(0, 63), $urandom, 1'b0);
          end else if (written_prefix(f) == anf_pkg::NAME_MAX) begin
            put_header(f, $urandom_range(0, 63), $urandom, 1'b1);
          end else begin
            put_header(f, $urandom_range(0, written_prefix(f)), $urandom, 1'b1);
          end
        end
        4: send_item(blank_item(REQ_NONE));
        default: send_packet();
      endcase
    end
  endtask

  initial begin
    logic [7:0] pkt [$];
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    name_pool = {8'h61, 8'h62, 8'h63, 8'h64};
    for (int f = 0; f < anf_pkg::FILTERS; f++)
      for (int c = 0; c < anf_pkg::NAME_MAX; c++) char_set[f][c] = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = anf_pkg::REQ_PAYLOAD;
    in_if.data_byte = '0;
    in_if.last = 1'b0;
    in_if.filter_index = '0;
    in_if.char_index = '0;
    in_if.filter_length = '0;
    in_if.filter_exact = 1'b0;
    in_if.filter_valid = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table passes all, a short name, then exact and empty substring filters.
    pkt = {8'd3, anf_pkg::AD_NAME_SHORT, 8'h61, 8'h62};
    send_bytes(pkt);
    put_char(0, 0, 8'h61);
    put_char(0, 1, 8'h62);
    put_header(0, 2, 1'b1, 1'b1);
    send_bytes(pkt);
    pkt = {8'd4, anf_pkg::AD_NAME_FULL, 8'h63, 8'h61, 8'h62};
    send_bytes(pkt);
    put_header(7, 0, 1'b0, 1'b1);
    send_bytes(pkt);
    // Zero length byte, a cut-off structure, an unknown request, a non-name type.
    pkt = {8'd0};
    send_bytes(pkt);
    pkt = {8'd5, anf_pkg::AD_NAME_FULL, 8'hff};
    send_bytes(pkt);
    send_item(blank_item(REQ_NONE));
    pkt = {8'd2, 8'hff, 8'h00};
    send_bytes(pkt);
    put_header(7, 0, 1'b0, 1'b0);
    put_header(0, 63, 1'b1, 1'b0);
    wait_drained();

    // No idling, with a long result hold-off so the block backs up.
    hold_left = 3000;
    random_phase(210);
    wait_drained();
    send_idle_pct = 82;
    recv_stall_pct = 0;
    random_phase(210);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 82;
    random_phase(210);
    wait_drained();
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_phase(220);
    wait_drained();

    repeat (200) @(negedge clk);
    if (board.mismatches == 0 && board.verdict_q.size() == 0) begin
      $display("tb_adv_name_filter: done, clean");
    end else begin
      $display("tb_adv_name_filter: done, errors");
    end
    $finish;
  end

endmodule
